/* hw/rtl/max_key_disjoint_set_assert.svh */
// ----------------------------------------------------------------------------
// max_key_disjoint_set assertion macros
// concurrent assertion shorthands clocked on clk_i, disabled during reset
// ----------------------------------------------------------------------------
`ifndef MAX_KEY_DISJOINT_SET_ASSERT_SVH
`define MAX_KEY_DISJOINT_SET_ASSERT_SVH

// same-cycle implication
`define MKDS_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mkds assertion failed");

// next-cycle implication
`define MKDS_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mkds assertion failed");

`endif

/* hw/rtl/mkds_pkg.sv */
// ----------------------------------------------------------------------------
// mkds_pkg
// shared constants, codes and controller/datapath types
// ----------------------------------------------------------------------------
package mkds_pkg;

  // table size and derived widths
  localparam int unsigned MAX_ELEMENTS = 16384;
  localparam int unsigned IDX_W        = 14;
  localparam int unsigned SCORE_W      = 32;
  localparam int unsigned STEP_W       = $clog2(MAX_ELEMENTS + 1);
  localparam int unsigned FUNC_W       = 2;
  localparam int unsigned STATUS_W     = 2;

  // item operation codes
  typedef enum logic [FUNC_W-1:0] {
    FUNC_INIT  = 2'd0,
    FUNC_MERGE = 2'd1,
    FUNC_QUERY = 2'd2
  } mkds_func_e;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_DONE    = 2'd0,
    ST_INVALID = 2'd1,
    ST_EQUAL   = 2'd2,
    ST_QUERY   = 2'd3
  } mkds_status_e;

  // controller to datapath
  typedef struct packed {
    logic ready;      // input channel may take a transaction
    logic start_a;    // begin root walk at first element
    logic start_b;    // begin root walk at second element
    logic advance;    // follow parent link one step
    logic capture_a;  // latch root and score of first walk
    logic capture_b;  // latch root and score of second walk
    logic finish;     // write tables and load result register
  } mkds_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic req_fire;   // input transaction this cycle
    logic is_merge;
    logic is_query;
    logic in_range;   // element indexes fit the table
    logic at_root;    // current walk element is its own parent or the walk hit its step limit
    logic out_free;   // result register can take a new result
  } mkds_sts_t;

endpackage

/* hw/rtl/mkds_req_if.sv */
// ----------------------------------------------------------------------------
// mkds_req_if
// request channel: operation, element indexes and score
// ----------------------------------------------------------------------------
interface mkds_req_if;
  logic                          valid;
  logic                          ready;
  logic [mkds_pkg::FUNC_W-1:0]   func;
  logic [mkds_pkg::IDX_W-1:0]    index;
  logic [mkds_pkg::IDX_W-1:0]    other_index;
  logic [mkds_pkg::SCORE_W-1:0]  score;

  modport source (output valid, func, index, other_index, score, input ready);
  modport sink   (input valid, func, index, other_index, score, output ready);
endinterface

/* hw/rtl/mkds_rsp_if.sv */
// ----------------------------------------------------------------------------
// mkds_rsp_if
// response channel: status and owning root
// ----------------------------------------------------------------------------
interface mkds_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [mkds_pkg::STATUS_W-1:0] status;
  logic [mkds_pkg::IDX_W-1:0]    owner;

  modport source (output valid, status, owner, input ready);
  modport sink   (input valid, status, owner, output ready);
endinterface

/* hw/rtl/max_key_disjoint_set.sv */
// Init passes from decode straight to the result state; query walks from the element
// to its root; merge walks from both elements to their roots in turn.
// Each parent-chain step is one read of the parent table memory (S_READ) and
// one compare of the registered read data (S_CHECK). One item is in work at a time;
// the next is taken the cycle after the result is registered.
// Reset clears control only; table entries are undefined until initialized.
// ----------------------------------------------------------------------------
// max_key_disjoint_set
// disjoint-set engine where the higher-scored root owns a merged set
// ----------------------------------------------------------------------------
module max_key_disjoint_set (
  input  logic       clk_i,
  input  logic       rst_ni,
  mkds_req_if.sink   req_i,
  mkds_rsp_if.source rsp_o
);

  mkds_pkg::mkds_cmd_t cmd;
  mkds_pkg::mkds_sts_t sts;

  // sequencer
  mkds_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  // tables and result path
  mkds_datapath u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .req_i  (req_i),
    .rsp_o  (rsp_o)
  );

endmodule

/* hw/rtl/mkds_ram.sv */
// ----------------------------------------------------------------------------
// mkds_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module mkds_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/mkds_ctrl.sv */
// ----------------------------------------------------------------------------
// mkds_ctrl
// sequencer for init, merge and query: decode, root walks, result write-back
// ----------------------------------------------------------------------------
`include "max_key_disjoint_set_assert.svh"

module mkds_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mkds_pkg::mkds_sts_t sts_i,
  output mkds_pkg::mkds_cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_READ   = 3'd2;
  localparam logic [2:0] S_CHECK  = 3'd3;
  localparam logic [2:0] S_RESP   = 3'd4;

  logic [2:0] state_q, state_d;
  logic       walk_b_q, walk_b_d;

  // next state and commands
  always_comb begin
    state_d  = state_q;
    walk_b_d = walk_b_q;
    cmd_o    = '0;
    case (state_q)
      S_IDLE: begin
        cmd_o.ready = 1'b1;
        if (sts_i.req_fire) begin
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        if ((sts_i.is_merge || sts_i.is_query) && sts_i.in_range) begin
          cmd_o.start_a = 1'b1;
          walk_b_d      = 1'b0;
          state_d       = S_READ;
        end else begin
          state_d = S_RESP;
        end
      end
      S_READ: begin
        state_d = S_CHECK;
      end
      S_CHECK: begin
        if (!sts_i.at_root) begin
          cmd_o.advance = 1'b1;
          state_d       = S_READ;
        end else if (walk_b_q) begin
          cmd_o.capture_b = 1'b1;
          state_d         = S_RESP;
        end else begin
          cmd_o.capture_a = 1'b1;
          if (sts_i.is_merge) begin
            cmd_o.start_b = 1'b1;
            walk_b_d      = 1'b1;
            state_d       = S_READ;
          end else begin
            state_d = S_RESP;
          end
        end
      end
      S_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      walk_b_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      walk_b_q <= walk_b_d;
    end
  end

  // checks
  `MKDS_ASSERT_NEXT(a_accept_decodes, state_q == S_IDLE && sts_i.req_fire, state_q == S_DECODE)
  `MKDS_ASSERT_NOW(a_finish_needs_slot, cmd_o.finish, sts_i.out_free)
  `MKDS_ASSERT_NOW(a_one_walk_action, 1'b1, $onehot0({cmd_o.advance, cmd_o.capture_a, cmd_o.capture_b}))
  `MKDS_ASSERT_NOW(a_second_walk_merge, walk_b_q && state_q == S_CHECK, sts_i.is_merge)

endmodule

/* hw/rtl/mkds_datapath.sv */
// ----------------------------------------------------------------------------
// mkds_datapath
// item registers, parent and score tables, root walk and result register
// ----------------------------------------------------------------------------
module mkds_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mkds_pkg::mkds_cmd_t  cmd_i,
  output mkds_pkg::mkds_sts_t  sts_o,
  mkds_req_if.sink             req_i,
  mkds_rsp_if.source           rsp_o
);

  logic [mkds_pkg::FUNC_W-1:0]   func_q;
  logic [mkds_pkg::IDX_W-1:0]    a_q, b_q;
  logic [mkds_pkg::SCORE_W-1:0]  score_q;
  logic [mkds_pkg::IDX_W-1:0]    cur_q;
  logic [mkds_pkg::STEP_W-1:0]   steps_q;
  logic [mkds_pkg::IDX_W-1:0]    ra_q, rb_q;
  logic [mkds_pkg::SCORE_W-1:0]  sa_q, sb_q;
  logic                          out_valid_q, out_valid_d;
  logic [mkds_pkg::STATUS_W-1:0] status_q, status_d;
  logic [mkds_pkg::IDX_W-1:0]    owner_q, owner_d;

  logic [mkds_pkg::IDX_W-1:0]    par_rdata;
  logic [mkds_pkg::SCORE_W-1:0]  score_rdata;
  logic                          par_we, score_we;
  logic [mkds_pkg::IDX_W-1:0]    par_waddr, par_wdata;
  logic                          req_fire;
  logic                          a_ok, b_ok;

  assign req_fire    = req_i.valid && cmd_i.ready;
  assign req_i.ready = cmd_i.ready;

  // transaction capture
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      func_q  <= req_i.func;
      a_q     <= req_i.index;
      b_q     <= req_i.other_index;
      score_q <= req_i.score;
    end
  end

  // walk pointer and step count
  always_ff @(posedge clk_i) begin
    if (cmd_i.start_a) begin
      cur_q   <= a_q;
      steps_q <= '0;
    end else if (cmd_i.start_b) begin
      cur_q   <= b_q;
      steps_q <= '0;
    end else if (cmd_i.advance) begin
      cur_q   <= par_rdata;
      steps_q <= steps_q + mkds_pkg::STEP_W'(1);
    end
  end

  // roots and their scores
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture_a) begin
      ra_q <= cur_q;
      sa_q <= score_rdata;
    end
    if (cmd_i.capture_b) begin
      rb_q <= cur_q;
      sb_q <= score_rdata;
    end
  end

  // tables, both read at the walk pointer
  mkds_ram #(
    .WIDTH (mkds_pkg::IDX_W),
    .DEPTH (mkds_pkg::MAX_ELEMENTS)
  ) u_parent_ram (
    .clk_i   (clk_i),
    .we_i    (par_we),
    .waddr_i (par_waddr),
    .wdata_i (par_wdata),
    .raddr_i (cur_q),
    .rdata_o (par_rdata)
  );

  mkds_ram #(
    .WIDTH (mkds_pkg::SCORE_W),
    .DEPTH (mkds_pkg::MAX_ELEMENTS)
  ) u_score_ram (
    .clk_i   (clk_i),
    .we_i    (score_we),
    .waddr_i (a_q),
    .wdata_i (score_q),
    .raddr_i (cur_q),
    .rdata_o (score_rdata)
  );

  // range checks
  assign a_ok = {1'b0, a_q} < mkds_pkg::STEP_W'(mkds_pkg::MAX_ELEMENTS);
  assign b_ok = {1'b0, b_q} < mkds_pkg::STEP_W'(mkds_pkg::MAX_ELEMENTS);

  // result and table write-back
  always_comb begin
    status_d  = mkds_pkg::ST_INVALID;
    owner_d   = '0;
    par_we    = 1'b0;
    score_we  = 1'b0;
    par_waddr = a_q;
    par_wdata = a_q;
    case (func_q)
      mkds_pkg::FUNC_INIT: begin
        if (a_ok) begin
          status_d = mkds_pkg::ST_DONE;
          owner_d  = a_q;
          par_we   = cmd_i.finish;
          score_we = cmd_i.finish;
        end
      end
      mkds_pkg::FUNC_MERGE: begin
        if (a_ok && b_ok) begin
          if (ra_q == rb_q) begin
            status_d = mkds_pkg::ST_INVALID;
            owner_d  = ra_q;
          end else if (sa_q > sb_q) begin
            status_d  = mkds_pkg::ST_DONE;
            owner_d   = ra_q;
            par_we    = cmd_i.finish;
            par_waddr = rb_q;
            par_wdata = ra_q;
          end else if (sa_q < sb_q) begin
            status_d  = mkds_pkg::ST_DONE;
            owner_d   = rb_q;
            par_we    = cmd_i.finish;
            par_waddr = ra_q;
            par_wdata = rb_q;
          end else begin
            status_d = mkds_pkg::ST_EQUAL;
            owner_d  = ra_q;
          end
        end
      end
      mkds_pkg::FUNC_QUERY: begin
        if (a_ok) begin
          status_d = mkds_pkg::ST_QUERY;
          owner_d  = ra_q;
        end
      end
      default: begin
        status_d = mkds_pkg::ST_INVALID;
      end
    endcase
  end

  // result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.finish) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      status_q <= status_d;
      owner_q  <= owner_d;
    end
  end

  assign rsp_o.valid  = out_valid_q;
  assign rsp_o.status = status_q;
  assign rsp_o.owner  = owner_q;

  // status to controller
  assign sts_o.req_fire = req_fire;
  assign sts_o.is_merge = func_q == mkds_pkg::FUNC_MERGE;
  assign sts_o.is_query = func_q == mkds_pkg::FUNC_QUERY;
  assign sts_o.in_range = a_ok && (b_ok || func_q != mkds_pkg::FUNC_MERGE);
  assign sts_o.at_root  = (par_rdata == cur_q)
                       || ({1'b0, par_rdata} >= mkds_pkg::STEP_W'(mkds_pkg::MAX_ELEMENTS))
                       || (steps_q == mkds_pkg::STEP_W'(mkds_pkg::MAX_ELEMENTS));
  assign sts_o.out_free = !out_valid_q || rsp_o.ready;

endmodule
